// ===== rtl/oel_pkg.sv =====
`default_nettype none

package oel_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;

    // Width of position, length and count inside the cell control bundle;
    // covers depths up to 2047 entries (count up to 2047)
    localparam int POS_MAX_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_GET    = 3'd3,
        OP_FIND   = 3'd4,
        OP_REMOVE = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_RESIZE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CA_HOLD,
        CA_INSERT,
        CA_SET,
        CA_SHIFT_DN,
        CA_ZERO
    } cell_act_t;

    typedef struct packed {
        cell_act_t              act;
        logic [POS_MAX_W-1:0]   pos;
        logic [POS_MAX_W-1:0]   len;
        logic [POS_MAX_W-1:0]   count;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/ordered_entry_list_engine.sv =====
// Channel   | Dir | Handshake                    | Payload (tdata, low bit first)
// s_axis    | in  | s_axis_tvalid / s_axis_tready| op, position, run_length, value
// m_axis    | out | m_axis_tvalid / m_axis_tready| ok, found_position, read_value,
//           |     |                              | entry_count, list_empty
//
// One operation at a time. An accepted transaction passes the evaluate state
// and then the finish state, and the result is registered as the finish state
// is left; no new transaction is taken before that. Remove runs the shift state
// in between, one shift per removed entry, moving data one place per cycle.
// Reset clears the count, the state machine and the output valid; entry
// contents are not reset. A stalled result holds in the finish state until the
// output register frees up, with s_axis_tready low.
`default_nettype none

module ordered_entry_list_engine #(
    parameter int DEPTH     = oel_pkg::DEPTH_DEF,
    parameter int WORD_BITS = oel_pkg::WORD_BITS_DEF,
    localparam int IDX_W    = $clog2(DEPTH),
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IN_BITS  = oel_pkg::OP_W + 2 * CNT_W + oel_pkg::VALUE_W,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 1 + IDX_W + oel_pkg::VALUE_W + CNT_W + 1,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // op, position, run_length, value
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // ok, found_position, read_value, entry_count, list_empty
    output logic      [OUT_W-1:0]  m_axis_tdata
);

    localparam int POS_LO   = oel_pkg::OP_W;
    localparam int LEN_LO   = POS_LO + CNT_W;
    localparam int VAL_LO   = LEN_LO + CNT_W;
    localparam int PW       = oel_pkg::POS_MAX_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    oel_pkg::state_t        state_reg;
    oel_pkg::state_t        state_next;
    oel_pkg::op_t           op_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       len_reg;
    logic [WORD_BITS-1:0]   value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       shift_reg;
    logic [CNT_W-1:0]       shift_next;
    logic                   ok_reg;
    logic                   ok_next;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;

    logic                   in_fire;
    logic                   out_free;
    logic                   legal;
    logic [CNT_W:0]         run_end;
    logic                   full;
    oel_pkg::cell_ctrl_t    ctrl;

    logic [WORD_BITS-1:0]   cell_data [DEPTH];
    logic [WORD_BITS-1:0]   cell_rd   [DEPTH];
    logic [DEPTH-1:0]       hit_vec;

    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [WORD_BITS-1:0]   rd_any;
    logic                   res_ok;
    logic [IDX_W-1:0]       res_found;
    logic [WORD_BITS-1:0]   res_rd;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    // Legality of the held operation against the current fill level
    always_comb
    begin
        full    = (count_reg == DEPTH_CNT);
        run_end = {1'b0, pos_reg} + {1'b0, len_reg};
        case (op_reg)
            oel_pkg::OP_APPEND: legal = !full;
            oel_pkg::OP_INSERT: legal = !full && (pos_reg <= count_reg);
            oel_pkg::OP_SET:    legal = pos_reg < count_reg;
            oel_pkg::OP_GET:    legal = pos_reg < count_reg;
            oel_pkg::OP_FIND:   legal = 1'b1;
            oel_pkg::OP_REMOVE: legal = (len_reg != '0) && (run_end <= {1'b0, count_reg});
            oel_pkg::OP_CLEAR:  legal = 1'b1;
            oel_pkg::OP_RESIZE: legal = len_reg <= DEPTH_CNT;
            default:            legal = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oel_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = oel_pkg::S_EVAL;
                end
            end
            oel_pkg::S_EVAL:
            begin
                if ((op_reg == oel_pkg::OP_REMOVE) && legal)
                begin
                    state_next = oel_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = oel_pkg::S_FIN;
                end
            end
            oel_pkg::S_SHIFT:
            begin
                if (shift_reg == CNT_W'(1))
                begin
                    state_next = oel_pkg::S_FIN;
                end
            end
            oel_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = oel_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oel_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: cell commands, count and shift updates
    always_comb
    begin
        s_axis_tready = (state_reg == oel_pkg::S_IDLE);
        ctrl.act      = oel_pkg::CA_HOLD;
        ctrl.pos      = (op_reg == oel_pkg::OP_APPEND) ? PW'(count_reg) : PW'(pos_reg);
        ctrl.len      = PW'(len_reg);
        ctrl.count    = PW'(count_reg);
        count_next    = count_reg;
        shift_next    = shift_reg;
        ok_next       = ok_reg;
        case (state_reg)
            oel_pkg::S_EVAL:
            begin
                ok_next = legal;
                if (legal)
                begin
                    case (op_reg)
                        oel_pkg::OP_APPEND,
                        oel_pkg::OP_INSERT:
                        begin
                            ctrl.act   = oel_pkg::CA_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                        oel_pkg::OP_SET:
                        begin
                            ctrl.act = oel_pkg::CA_SET;
                        end
                        oel_pkg::OP_REMOVE:
                        begin
                            // drop the count now, let the chain catch up
                            count_next = count_reg - len_reg;
                            shift_next = len_reg;
                        end
                        oel_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        oel_pkg::OP_RESIZE:
                        begin
                            ctrl.act   = oel_pkg::CA_ZERO;
                            count_next = len_reg;
                        end
                        default:
                        begin
                            ctrl.act = oel_pkg::CA_HOLD;
                        end
                    endcase
                end
            end
            oel_pkg::S_SHIFT:
            begin
                ctrl.act   = oel_pkg::CA_SHIFT_DN;
                shift_next = shift_reg - CNT_W'(1);
            end
            default:
            begin
                ctrl.act = oel_pkg::CA_HOLD;
            end
        endcase
    end

    // Cell chain: cell i takes from i-1 on insert, from i+1 on remove
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (gi == 0)
        begin : g_first
            assign left_w = value_reg;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[gi+1];
        end

        oel_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (gi)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (value_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[gi]),
            .hit        (hit_vec[gi]),
            .rd_data    (cell_rd[gi])
        );
    end

    // Collect the registered per-cell compare and read results:
    // lowest hit wins, read words are zero everywhere but the addressed cell
    always_comb
    begin
        any_hit = |hit_vec;
        hit_idx = '0;
        rd_any  = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb
    begin
        res_ok    = (op_reg == oel_pkg::OP_FIND) ? any_hit : ok_reg;
        res_found = ((op_reg == oel_pkg::OP_FIND) && any_hit) ? hit_idx : '0;
        res_rd    = ((op_reg == oel_pkg::OP_GET) && ok_reg) ? rd_any : '0;
        m_tdata_next = OUT_W'({(count_reg == '0), count_reg,
                               oel_pkg::VALUE_W'(res_rd), res_found, res_ok});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= oel_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == oel_pkg::S_FIN) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload captured on accept, held otherwise; also shift, ok, result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= oel_pkg::op_t'(s_axis_tdata[oel_pkg::OP_W-1:0]);
            pos_reg   <= s_axis_tdata[POS_LO +: CNT_W];
            len_reg   <= s_axis_tdata[LEN_LO +: CNT_W];
            value_reg <= WORD_BITS'(s_axis_tdata[VAL_LO +: oel_pkg::VALUE_W]);
        end
        shift_reg <= shift_next;
        ok_reg    <= ok_next;
        if ((state_reg == oel_pkg::S_FIN) && out_free)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/oel_cell.sv =====
`default_nettype none

module oel_cell #(
    parameter int WORD_BITS = oel_pkg::WORD_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  wire logic                  clk,
    input  wire oel_pkg::cell_ctrl_t   ctrl,
    input  wire logic [WORD_BITS-1:0]  value,
    input  wire logic [WORD_BITS-1:0]  left_data,
    input  wire logic [WORD_BITS-1:0]  right_data,
    output logic      [WORD_BITS-1:0]  data,
    output logic                       hit,
    output logic      [WORD_BITS-1:0]  rd_data
);

    localparam logic [oel_pkg::POS_MAX_W-1:0] MY_IDX = oel_pkg::POS_MAX_W'(INDEX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [WORD_BITS-1:0] rd_reg;
    logic [WORD_BITS-1:0] rd_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.act)
            oel_pkg::CA_INSERT:
            begin
                // take the left neighbor above the slot, the new word at it
                if (MY_IDX > ctrl.pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == ctrl.pos)
                begin
                    data_next = value;
                end
            end
            oel_pkg::CA_SET:
            begin
                if (MY_IDX == ctrl.pos)
                begin
                    data_next = value;
                end
            end
            oel_pkg::CA_SHIFT_DN:
            begin
                if (MY_IDX >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            oel_pkg::CA_ZERO:
            begin
                if (MY_IDX < ctrl.len)
                begin
                    data_next = '0;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // compare and select against the stored word, masked by the fill level
    always_comb
    begin
        hit_next = (data_reg == value) && (MY_IDX < ctrl.count);
        rd_next  = (MY_IDX == ctrl.pos) ? data_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
        rd_reg   <= rd_next;
    end

    assign data    = data_reg;
    assign hit     = hit_reg;
    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ===== tb/ordered_entry_list_engine_check.sv =====
`timescale 1ns / 1ps

module ordered_entry_list_engine_check #(
    parameter int IN_W  = 56,
    parameter int OUT_W = 48
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic              cmd_ready,
    // op, position, run_length, value
    input  wire logic [IN_W-1:0]   cmd_data,
    input  wire logic              reply_valid,
    input  wire logic              reply_ready,
    // ok, found_position, read_value, entry_count, list_empty
    input  wire logic [OUT_W-1:0]  reply_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic        ok;
        logic [5:0]  found_position;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
        logic        list_empty;
    } list_reply_t;

    logic [31:0] shadow_words [DEPTH];
    int          shadow_count = 0;
    list_reply_t expected_replies [$];
    int          error_total = 0;

    assign mismatches = error_total;

    // Apply one command to the shadow list and return the reply it should give.
    function automatic list_reply_t apply_cmd(oel_pkg::op_t op, int pos, int len,
                                              logic [31:0] word);
        list_reply_t r;
        int          i;
        r = '0;
        case (op)
            oel_pkg::OP_APPEND, oel_pkg::OP_INSERT:
            begin
                if (op == oel_pkg::OP_APPEND)
                    pos = shadow_count;
                if (shadow_count < DEPTH && pos <= shadow_count)
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = word;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            oel_pkg::OP_SET:
            begin
                if (pos < shadow_count)
                begin
                    shadow_words[pos] = word;
                    r.ok = 1'b1;
                end
            end
            oel_pkg::OP_GET:
            begin
                if (pos < shadow_count)
                begin
                    r.read_value = shadow_words[pos];
                    r.ok = 1'b1;
                end
            end
            oel_pkg::OP_FIND:
            begin
                // scan downward so the lowest match is the one kept
                for (i = shadow_count - 1; i >= 0; i--)
                begin
                    if (shadow_words[i] == word)
                    begin
                        r.ok = 1'b1;
                        r.found_position = i[5:0];
                    end
                end
            end
            oel_pkg::OP_REMOVE:
            begin
                if (len > 0 && pos + len <= shadow_count)
                begin
                    for (i = pos; i + len < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+len];
                    shadow_count -= len;
                    r.ok = 1'b1;
                end
            end
            oel_pkg::OP_CLEAR:
            begin
                shadow_count = 0;
                r.ok = 1'b1;
            end
            default:
            begin
                if (len <= DEPTH)
                begin
                    for (i = 0; i < len; i++)
                        shadow_words[i] = '0;
                    shadow_count = len;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.entry_count = shadow_count[6:0];
        r.list_empty  = (shadow_count == 0);
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_reply_t want;
        if (!rst_n)
        begin
            expected_replies.delete();
            shadow_count = 0;
            pending <= 0;
        end
        else
        begin
            // retire the result first: it can never belong to a command taken this edge
            if (reply_valid && reply_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result 0x%0h", reply_data);
                    error_total++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("ok", want.ok, reply_data[0]);
                    compare_field("found_position", want.found_position, reply_data[6:1]);
                    compare_field("read_value", want.read_value, reply_data[38:7]);
                    compare_field("entry_count", want.entry_count, reply_data[45:39]);
                    compare_field("list_empty", want.list_empty, reply_data[46]);
                end
            end
            if (cmd_valid && cmd_ready)
                expected_replies.push_back(apply_cmd(oel_pkg::op_t'(cmd_data[2:0]),
                                                     int'(cmd_data[9:3]),
                                                     int'(cmd_data[16:10]),
                                                     cmd_data[48:17]));
            pending <= expected_replies.size();
        end
    end

endmodule

// ===== tb/ordered_entry_list_engine_tb.sv =====
`timescale 1ns / 1ps

module ordered_entry_list_engine_tb;

    localparam int DEPTH          = 64;
    localparam int IN_W           = 56;   // 49 payload bits padded to bytes
    localparam int OUT_W          = 48;   // 47 payload bits padded to bytes
    localparam int OPS_PER_PHASE  = 550;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 100;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             s_axis_tvalid  = 1'b0;
    logic             s_axis_tready;
    // op, position, run_length, value
    logic [IN_W-1:0]  s_axis_tdata   = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready  = 1'b0;
    // ok, found_position, read_value, entry_count, list_empty
    logic [OUT_W-1:0] m_axis_tdata;

    int mismatches;
    int pending_replies;

    // Idle odds in percent for the command side and the result side
    int feed_idle_pct   = 36;
    int drain_stall_pct = 65;

    // Entry count as the stimulus sees it; used only to aim positions and lengths
    int fill_level   = 0;
    int quiet_cycles = 0;

    // Small set of recurring words so that find hits often
    logic [31:0] word_pool [8];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ordered_entry_list_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ordered_entry_list_engine_check #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd_data    (s_axis_tdata),
        .reply_valid (m_axis_tvalid),
        .reply_ready (m_axis_tready),
        .reply_data  (m_axis_tdata),
        .mismatches  (mismatches),
        .pending     (pending_replies)
    );

    // Stall the result side at random with the current odds
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= drain_stall_pct);

    // Count cycles without any transaction; give up when the block hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("[ordered_entry_list_engine] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Entry count after a command, so later commands can target valid positions
    function automatic int fill_after(oel_pkg::op_t op, int pos, int len, int fill);
        case (op)
            oel_pkg::OP_APPEND: return (fill < DEPTH) ? fill + 1 : fill;
            oel_pkg::OP_INSERT: return (fill < DEPTH && pos <= fill) ? fill + 1 : fill;
            oel_pkg::OP_REMOVE: return (len > 0 && pos + len <= fill) ? fill - len : fill;
            oel_pkg::OP_CLEAR:  return 0;
            oel_pkg::OP_RESIZE: return (len <= DEPTH) ? len : fill;
            default:            return fill;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(99) < 60)
            return word_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Drive one command and hold it until the block takes it; idle first at random
    task automatic send_op(oel_pkg::op_t op, int pos, int len, logic [31:0] word);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({word, 7'(len), 7'(pos), op});
        do
            @(posedge clk);
        while (!s_axis_tready);
        fill_level = fill_after(op, pos, len, fill_level);
    endtask

    // Drop valid and hold off until every result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies != 0);
    endtask

    // Mostly well-formed commands aimed at the current contents, some raw noise
    task automatic send_random_op();
        int           pick;
        int           pos;
        int           len;
        int           room;
        oel_pkg::op_t op;
        logic [31:0]  word;
        word = pick_word();
        if ($urandom_range(99) < 12)
        begin
            send_op(oel_pkg::op_t'($urandom_range(7)), $urandom_range(127),
                    $urandom_range(127), $urandom);
            return;
        end
        pick = $urandom_range(99);
        pos  = 0;
        len  = 0;
        if (pick < 22)
            op = oel_pkg::OP_APPEND;
        else if (pick < 40)
        begin
            op  = oel_pkg::OP_INSERT;
            pos = $urandom_range(fill_level);
        end
        else if (pick < 52)
        begin
            op  = oel_pkg::OP_SET;
            pos = (fill_level > 0) ? $urandom_range(fill_level - 1) : 0;
        end
        else if (pick < 66)
        begin
            op  = oel_pkg::OP_GET;
            pos = (fill_level > 0) ? $urandom_range(fill_level - 1) : 0;
        end
        else if (pick < 82)
            op = oel_pkg::OP_FIND;
        else if (pick < 94)
        begin
            op  = oel_pkg::OP_REMOVE;
            len = 1;
            if (fill_level > 0)
            begin
                pos  = $urandom_range(fill_level - 1);
                room = fill_level - pos;
                // short runs mostly; now and then take the whole tail
                if ($urandom_range(9) == 0)
                    len = room;
                else
                    len = 1 + $urandom_range(((room < 4) ? room : 4) - 1);
            end
        end
        else if (pick < 96)
            op = oel_pkg::OP_CLEAR;
        else
        begin
            op  = oel_pkg::OP_RESIZE;
            len = ($urandom_range(19) == 0) ? DEPTH : $urandom_range(8);
        end
        send_op(op, pos, len, word);
    endtask

    initial
    begin
        word_pool[0] = 32'h0000_0000;
        word_pool[1] = 32'hFFFF_FFFF;
        word_pool[2] = 32'h8000_0001;
        for (int i = 3; i < 8; i++)
            word_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, edges of every field, full list and bad arguments
        send_op(oel_pkg::OP_CLEAR,  0,  0,   32'h0);
        send_op(oel_pkg::OP_GET,    0,  0,   32'h0);           // read on empty list
        send_op(oel_pkg::OP_REMOVE, 0,  1,   32'h0);           // remove on empty list
        send_op(oel_pkg::OP_FIND,   0,  0,   32'h0);           // find on empty list
        send_op(oel_pkg::OP_APPEND, 0,  0,   32'h0000_0000);
        send_op(oel_pkg::OP_APPEND, 0,  0,   32'hFFFF_FFFF);
        send_op(oel_pkg::OP_INSERT, 0,  0,   32'hA5A5_A5A5);   // insert at head shifts up
        send_op(oel_pkg::OP_INSERT, 3,  0,   32'h1234_5678);   // insert at end acts as append
        send_op(oel_pkg::OP_INSERT, 6,  0,   32'h5A5A_5A5A);   // insert past the end
        send_op(oel_pkg::OP_SET,    1,  0,   32'hFFFF_FFFF);   // duplicate for find
        send_op(oel_pkg::OP_SET,    4,  0,   32'h0);           // set past the end
        send_op(oel_pkg::OP_GET,    3,  0,   32'h0);
        send_op(oel_pkg::OP_GET,    64, 0,   32'h0);           // top position bit
        send_op(oel_pkg::OP_FIND,   0,  0,   32'hFFFF_FFFF);   // lowest of two matches
        send_op(oel_pkg::OP_FIND,   0,  0,   32'h0);           // no match
        send_op(oel_pkg::OP_REMOVE, 1,  0,   32'h0);           // zero-length run
        send_op(oel_pkg::OP_REMOVE, 2,  3,   32'h0);           // run past the end
        send_op(oel_pkg::OP_REMOVE, 1,  2,   32'h0);           // run from the middle
        send_op(oel_pkg::OP_RESIZE, 0,  127, 32'h0);           // size above capacity
        send_op(oel_pkg::OP_RESIZE, 0,  64,  32'h0);           // fill to capacity with zeros
        send_op(oel_pkg::OP_APPEND, 0,  0,   32'hDEAD_BEEF);   // append on full list
        send_op(oel_pkg::OP_INSERT, 0,  0,   32'hDEAD_BEEF);   // insert on full list
        send_op(oel_pkg::OP_FIND,   0,  0,   32'h0);
        send_op(oel_pkg::OP_REMOVE, 0,  64,  32'h0);           // remove everything
        send_op(oel_pkg::OP_RESIZE, 0,  0,   32'h0);           // resize to empty

        wait_drained();

        // Random: result side stalls more, then command side idles more, then no idling at all
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    feed_idle_pct   = 36;
                    drain_stall_pct = 65;
                end
                1:
                begin
                    feed_idle_pct   = 65;
                    drain_stall_pct = 36;
                end
                default:
                begin
                    feed_idle_pct   = 0;
                    drain_stall_pct = 0;
                end
            endcase
            repeat (OPS_PER_PHASE) send_random_op();
            wait_drained();
        end

        // Let any stray output show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ordered_entry_list_engine] OK");
        else
            $display("[ordered_entry_list_engine] ERROR");
        $finish;
    end

endmodule

// ===== ordered_entry_list_engine.f =====
rtl/oel_pkg.sv
rtl/oel_cell.sv
rtl/ordered_entry_list_engine.sv
tb/ordered_entry_list_engine_check.sv
tb/ordered_entry_list_engine_tb.sv
